// ===== rtl/rsi_pkg.sv =====
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared widths, constants and helpers for the streaming RSI block.
// ----------------------------------------------------------------------------
package rsi_pkg;

    localparam int PRICE_BITS_DEF  = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int PERIOD_MAX_DEF  = 255;

    // accumulator widths at the default settings
    localparam int ACC_BITS_DEF    = 56;
    localparam int MUL_BITS_DEF    = 14;
    localparam int PROD_BITS_DEF   = 64;
    localparam int DEN_BITS_DEF    = 8;

    // fixed point arithmetic wraps at this width
    localparam int ACC_CAP         = 64;

    localparam int CFG_BITS        = 8;
    localparam int RSI_BITS        = 14;

    localparam logic [CFG_BITS-1:0] PERIOD_RESET = 8'd14;
    localparam logic [CFG_BITS-1:0] PERIOD_MIN   = 8'd2;
    localparam logic [RSI_BITS-1:0] RSI_FULL     = 14'd10000;

    function automatic int f_min(input int a, input int b);
        return (a < b) ? a : b;
    endfunction

    function automatic int f_max(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

// ===== rtl/rsi_smac.sv =====
// ----------------------------------------------------------------------------
// rsi_smac
// Bit-serial multiply-accumulate: prod = a * m + x, one multiplier bit a cycle.
// ----------------------------------------------------------------------------
module rsi_smac #(
    parameter int AW = rsi_pkg::ACC_BITS_DEF,
    parameter int MW = rsi_pkg::MUL_BITS_DEF,
    parameter int PW = rsi_pkg::PROD_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [AW-1:0] i_a,
    input  logic [MW-1:0] i_m,
    input  logic [PW-1:0] i_x,
    output logic          o_done,
    output logic [PW-1:0] o_prod
);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [PW-1:0] r_acc, n_acc;
    logic [PW-1:0] r_a, n_a;
    logic [MW-1:0] r_m, n_m;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_acc  = r_acc;
        n_a    = r_a;
        n_m    = r_m;
        if (i_start) begin
            n_acc  = i_x;
            n_a    = PW'(i_a);
            n_m    = i_m;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_m[0]) begin
                n_acc = r_acc + r_a;
            end
            n_a = r_a << 1;
            n_m = r_m >> 1;
            // stop as soon as no multiplier bits remain
            if (n_m == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_acc <= n_acc;
        r_a   <= n_a;
        r_m   <= n_m;
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ===== rtl/rsi_sdiv.sv =====
// ----------------------------------------------------------------------------
// rsi_sdiv
// Restoring divider, one quotient bit a cycle. Needs num >> QW below den.
// ----------------------------------------------------------------------------
module rsi_sdiv #(
    parameter int NW = rsi_pkg::PROD_BITS_DEF,
    parameter int DW = rsi_pkg::DEN_BITS_DEF,
    parameter int QW = rsi_pkg::ACC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [QW-1:0] o_quo
);

    localparam int CNW = $clog2(QW + 1);

    logic           r_busy, n_busy;
    logic           r_done, n_done;
    logic [CNW-1:0] r_cnt, n_cnt;
    logic [DW-1:0]  r_rem, n_rem;
    logic [DW-1:0]  r_den, n_den;
    logic [QW-1:0]  r_q, n_q;

    logic [DW:0]    trial;
    logic [DW:0]    trial_sub;
    logic           ge;

    assign trial     = {r_rem, r_q[QW-1]};
    assign ge        = (trial >= {1'b0, r_den});
    assign trial_sub = trial - {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_q    = r_q;
        if (i_start) begin
            // upper bits go straight to the remainder
            n_rem  = DW'(i_num >> QW);
            n_q    = QW'(i_num);
            n_den  = i_den;
            n_cnt  = CNW'(QW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = ge ? DW'(trial_sub) : DW'(trial);
            n_q   = {r_q[QW-2:0], ge};
            n_cnt = r_cnt - CNW'(1);
            if (r_cnt == CNW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_den <= n_den;
        r_q   <= n_q;
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

// ===== rtl/rsi_streaming_indicator.sv =====
// ----------------------------------------------------------------------------
// rsi_streaming_indicator
// Streaming Wilder relative strength index over unsigned integer prices.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall / i_price, one price sample per beat.
// Output channel: o_valid / i_stall / o_rsi_hundredths / o_rsi_ready, exactly
// one result beat for every input beat, in order.
// Config: i_cfg_we / i_cfg_data write the averaging period (reset 14); values
// below 2 act as 2, values above PERIOD_MAX act as PERIOD_MAX.
// One sample is worked on at a time; o_stall is high from the cycle after an
// accepted beat until its result is loaded into the output register.
// Flow: while the window is filling, a beat runs the two multiply-accumulate
// lanes and then loads its result. The beat that completes the window, and
// every later beat, also runs the bit-serial dividers that produce the new
// averages (one quotient bit a cycle), then the 14-step serial multiply by
// 10000 and the 14-step divide that give the index; beats whose average loss
// is zero skip those two.
// Reset (synchronous, active low) clears all history and the held index and
// restores the period. A stalled result sits in the output register; the
// block may already accept the next sample and only waits before loading
// its own result.
// ----------------------------------------------------------------------------
module rsi_streaming_indicator #(
    parameter int PRICE_BITS = rsi_pkg::PRICE_BITS_DEF,
    parameter int FRAC_BITS  = rsi_pkg::FRAC_BITS_DEF,
    parameter int PERIOD_MAX = rsi_pkg::PERIOD_MAX_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration
    input  logic                         i_cfg_we,
    input  logic [rsi_pkg::CFG_BITS-1:0] i_cfg_data,
    // input beats
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [PRICE_BITS-1:0]        i_price,
    // output beats
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [rsi_pkg::RSI_BITS-1:0] o_rsi_hundredths,
    output logic                         o_rsi_ready
);

    // period width, average width, multiplier width, product width, count width
    localparam int PB = $clog2(PERIOD_MAX + 1);
    localparam int AW = rsi_pkg::f_min(rsi_pkg::ACC_CAP, PRICE_BITS + FRAC_BITS + PB);
    localparam int MW = rsi_pkg::f_max(PB, rsi_pkg::RSI_BITS);
    localparam int PW = rsi_pkg::f_min(rsi_pkg::ACC_CAP, AW + MW);
    localparam int CW = $clog2(PERIOD_MAX + 2);
    localparam int QB = PRICE_BITS + FRAC_BITS;
    localparam int RB = rsi_pkg::RSI_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_DIV,
        S_RMUL,
        S_RDIV,
        S_OUT
    } t_state;

    t_state                     r_state, n_state;
    logic [rsi_pkg::CFG_BITS-1:0] r_period, n_period;
    logic [PRICE_BITS-1:0]      r_prev, n_prev;
    logic [CW-1:0]              r_count, n_count;
    logic [AW-1:0]              r_avg_g, n_avg_g;
    logic [AW-1:0]              r_avg_l, n_avg_l;
    logic                       r_seeded, n_seeded;
    logic [RB-1:0]              r_held, n_held;
    logic                       r_divide, n_divide;
    logic [AW-1:0]              r_total, n_total;
    logic                       r_out_vld, n_out_vld;
    logic [RB-1:0]              r_out_rsi, n_out_rsi;
    logic                       r_out_rdy, n_out_rdy;

    // change of price, split into gain and loss
    logic [PB-1:0]              eff_p;
    logic                       rise;
    logic [PRICE_BITS-1:0]      diff;
    logic [QB-1:0]              diff_q;
    logic [AW-1:0]              x_g, x_l;
    logic                       has_prev;
    logic [CW:0]                count_inc;
    logic [CW:0]                p_plus1;
    logic                       seed_now;
    logic [MW-1:0]              mul_p;

    // serial unit hookup
    logic                       gmac_start, lmac_start;
    logic [AW-1:0]              gmac_a;
    logic [MW-1:0]              gmac_m;
    logic [PW-1:0]              gmac_x;
    logic                       gmac_done, lmac_done;
    logic [PW-1:0]              prod_g, prod_l;
    logic                       adiv_start;
    logic                       div_done_g, div_done_l;
    logic [AW-1:0]              q_g, q_l;
    logic                       rdiv_start;
    logic                       div_done_r;
    logic [RB-1:0]              q_r;

    // clamp the period register
    always_comb begin
        if (r_period < rsi_pkg::PERIOD_MIN) begin
            eff_p = PB'(rsi_pkg::PERIOD_MIN);
        end else if (int'(r_period) > PERIOD_MAX) begin
            eff_p = PB'(PERIOD_MAX);
        end else begin
            eff_p = PB'(r_period);
        end
    end

    assign rise      = (i_price >= r_prev);
    assign diff      = rise ? (i_price - r_prev) : (r_prev - i_price);
    assign diff_q    = {diff, {FRAC_BITS{1'b0}}};
    // first sample has no predecessor, so it adds nothing
    assign has_prev  = r_seeded || (r_count != '0);
    assign x_g       = (has_prev && rise)  ? AW'(diff_q) : '0;
    assign x_l       = (has_prev && !rise) ? AW'(diff_q) : '0;
    assign count_inc = (CW + 1)'(r_count) + (CW + 1)'(1);
    assign p_plus1   = (CW + 1)'(eff_p) + (CW + 1)'(1);
    assign seed_now  = !r_seeded && (count_inc >= p_plus1);
    // smoothing: avg*(p-1) + x; seeding: sum*1 + x
    assign mul_p     = r_seeded ? (MW'(eff_p) - MW'(1)) : MW'(1);

    assign o_stall   = (r_state != S_IDLE);

    // gain lane multiplier is reused for 10000 * avg_gain
    assign gmac_start = ((r_state == S_IDLE) && i_valid) ||
                        ((r_state == S_DIV) && div_done_g && (q_l != '0));
    assign gmac_a     = (r_state == S_IDLE) ? r_avg_g : q_g;
    assign gmac_m     = (r_state == S_IDLE) ? mul_p : MW'(rsi_pkg::RSI_FULL);
    assign gmac_x     = (r_state == S_IDLE) ? PW'(x_g) : '0;
    assign lmac_start = (r_state == S_IDLE) && i_valid;

    assign adiv_start = (r_state == S_MAC) && gmac_done && r_divide;
    assign rdiv_start = (r_state == S_RMUL) && gmac_done;

    rsi_smac #(.AW(AW), .MW(MW), .PW(PW)) u_gmac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (gmac_start),
        .i_a     (gmac_a),
        .i_m     (gmac_m),
        .i_x     (gmac_x),
        .o_done  (gmac_done),
        .o_prod  (prod_g)
    );

    rsi_smac #(.AW(AW), .MW(MW), .PW(PW)) u_lmac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (lmac_start),
        .i_a     (r_avg_l),
        .i_m     (mul_p),
        .i_x     (PW'(x_l)),
        .o_done  (lmac_done),
        .o_prod  (prod_l)
    );

    rsi_sdiv #(.NW(PW), .DW(PB), .QW(AW)) u_gdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (adiv_start),
        .i_num   (prod_g),
        .i_den   (eff_p),
        .o_done  (div_done_g),
        .o_quo   (q_g)
    );

    rsi_sdiv #(.NW(PW), .DW(PB), .QW(AW)) u_ldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (adiv_start),
        .i_num   (prod_l),
        .i_den   (eff_p),
        .o_done  (div_done_l),
        .o_quo   (q_l)
    );

    // 10000*g / (g+l) always fits in 14 quotient bits
    rsi_sdiv #(.NW(PW), .DW(AW), .QW(RB)) u_rdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rdiv_start),
        .i_num   (prod_g),
        .i_den   (r_total),
        .o_done  (div_done_r),
        .o_quo   (q_r)
    );

    always_comb begin
        n_state   = r_state;
        n_period  = i_cfg_we ? i_cfg_data : r_period;
        n_prev    = r_prev;
        n_count   = r_count;
        n_avg_g   = r_avg_g;
        n_avg_l   = r_avg_l;
        n_seeded  = r_seeded;
        n_held    = r_held;
        n_divide  = r_divide;
        n_total   = r_total;
        n_out_vld = r_out_vld && i_stall;
        n_out_rsi = r_out_rsi;
        n_out_rdy = r_out_rdy;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_prev   = i_price;
                    n_divide = r_seeded || seed_now;
                    // count saturates at p+1
                    if (r_seeded || seed_now) begin
                        n_count = CW'(p_plus1);
                    end else begin
                        n_count = CW'(count_inc);
                    end
                    n_state = S_MAC;
                end
            end
            S_MAC: begin
                // both lanes run the same multiplier, so they finish together
                if (gmac_done && lmac_done) begin
                    if (r_divide) begin
                        n_state = S_DIV;
                    end else begin
                        n_avg_g = AW'(prod_g);
                        n_avg_l = AW'(prod_l);
                        n_state = S_OUT;
                    end
                end
            end
            S_DIV: begin
                if (div_done_g && div_done_l) begin
                    n_avg_g  = q_g;
                    n_avg_l  = q_l;
                    n_seeded = 1'b1;
                    n_total  = q_g + q_l;
                    if (q_l == '0) begin
                        n_held  = rsi_pkg::RSI_FULL;
                        n_state = S_OUT;
                    end else begin
                        n_state = S_RMUL;
                    end
                end
            end
            S_RMUL: begin
                if (gmac_done) begin
                    n_state = S_RDIV;
                end
            end
            S_RDIV: begin
                if (div_done_r) begin
                    n_held  = q_r;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_vld || !i_stall) begin
                    n_out_vld = 1'b1;
                    n_out_rsi = r_held;
                    n_out_rdy = r_seeded;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_period  <= rsi_pkg::PERIOD_RESET;
            r_prev    <= '0;
            r_count   <= '0;
            r_avg_g   <= '0;
            r_avg_l   <= '0;
            r_seeded  <= 1'b0;
            r_held    <= '0;
            r_out_vld <= 1'b0;
            r_out_rsi <= '0;
            r_out_rdy <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_period  <= n_period;
            r_prev    <= n_prev;
            r_count   <= n_count;
            r_avg_g   <= n_avg_g;
            r_avg_l   <= n_avg_l;
            r_seeded  <= n_seeded;
            r_held    <= n_held;
            r_out_vld <= n_out_vld;
            r_out_rsi <= n_out_rsi;
            r_out_rdy <= n_out_rdy;
        end
        r_divide <= n_divide;
        r_total  <= n_total;
    end

    assign o_valid          = r_out_vld;
    assign o_rsi_hundredths = r_out_rsi;
    assign o_rsi_ready      = r_out_rdy;

endmodule

// ===== rtl/rsi_checker.sv =====
// ----------------------------------------------------------------------------
// rsi_checker
// Port-level checks for the streaming RSI block, bound to the top level.
// ----------------------------------------------------------------------------
module rsi_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_stall,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic [rsi_pkg::RSI_BITS-1:0] o_rsi_hundredths,
    input logic                         o_rsi_ready
);

    // one sample in flight: an accepted beat blocks the next one
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input accepted again right after a beat");

    // once the window is full it stays full
    a_ready_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !$fell(o_rsi_ready))
        else $error("rsi_ready dropped without reset");

    a_rsi_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rsi_hundredths <= rsi_pkg::RSI_FULL))
        else $error("rsi above full scale");

    // nothing is held before the first full window
    a_zero_until_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_rsi_ready) |-> (o_rsi_hundredths == '0))
        else $error("rsi nonzero before window full");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_rsi_hundredths) &&
                                  $stable(o_rsi_ready)))
        else $error("stalled result beat changed");

endmodule

bind rsi_streaming_indicator rsi_checker u_rsi_checker (.*);
